// ----- hw/rtl/diag_weighted_gram_product_assert.svh -----
// Assertion macros for the weighted Gram product block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DIAG_WEIGHTED_GRAM_PRODUCT_ASSERT_SVH
`define DIAG_WEIGHTED_GRAM_PRODUCT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define DWGP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define DWGP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DWGP_ASSERT(name, prop, msg)
`define DWGP_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- hw/rtl/dwgp_pkg.sv -----
`timescale 1ns / 1ps

package dwgp_pkg;

  // Store geometry.
  localparam int unsigned MAX_ROWS = 8;
  localparam int unsigned MAX_COLS = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DIM_W    = 4;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned PROD2_W  = 2 * VAL_W;
  localparam int unsigned PROD3_W  = 3 * VAL_W;
  localparam int unsigned ACC_W    = 50;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_W  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } dwgp_state_e;

  // Sideband that travels down the pipeline with each read.
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_pair;
  } dwgp_tag_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] ka;
    logic [IDX_W-1:0] kb_row;
    logic [IDX_W-1:0] k;
    dwgp_tag_t        tag;
  } dwgp_issue_t;

  typedef struct packed {
    logic               mat_we;
    logic               wgt_we;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VAL_W-1:0]   data;
  } dwgp_wr_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic [ACC_W-1:0] product;
  } dwgp_res_t;

  // Register value of zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/dwgp_core.sv -----
`timescale 1ns / 1ps

module dwgp_core import dwgp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dwgp_wr_t    wr_i,
  input  dwgp_issue_t iss_i,
  output dwgp_res_t   res_o,
  output logic        busy_o
);

  // Matrix store with two read ports and weight store with one.
  logic [VAL_W-1:0] mat_mem [MAX_ROWS*MAX_COLS];
  logic [VAL_W-1:0] wgt_mem [MAX_COLS];

  logic signed [VAL_W-1:0] a_rd_q, b_rd_q, w_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.mat_we) begin
      mat_mem[{wr_i.row, wr_i.col}] <= wr_i.data;
    end
    if (wr_i.wgt_we) begin
      wgt_mem[wr_i.col] <= wr_i.data;
    end
    a_rd_q <= mat_mem[{iss_i.ka, iss_i.k}];
    b_rd_q <= mat_mem[{iss_i.kb_row, iss_i.k}];
    w_rd_q <= wgt_mem[iss_i.k];
  end

  // Stage valids.
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  dwgp_tag_t s1_tag_q, s2_tag_q, s3_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= iss_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // First product A(i,k)*A(j,k), then the weight, each behind a register.
  logic signed [PROD2_W-1:0] p_q;
  logic signed [VAL_W-1:0]   w2_q;
  logic signed [PROD3_W-1:0] t_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_sum;

  always_ff @(posedge clk_i) begin
    s1_tag_q <= iss_i.tag;
    s2_tag_q <= s1_tag_q;
    s3_tag_q <= s2_tag_q;
    p_q      <= a_rd_q * b_rd_q;
    w2_q     <= w_rd_q;
    t_q      <= p_q * w2_q;
    if (s3_vld_q) begin
      acc_q <= acc_sum;
    end
  end

  // Accumulate; the first term of a pair restarts the sum.
  always_comb begin
    acc_sum = (s3_tag_q.first ? '0 : acc_q)
            + {{(ACC_W-PROD3_W){t_q[PROD3_W-1]}}, t_q};
  end

  assign res_o.valid   = s3_vld_q && s3_tag_q.last_k;
  assign res_o.row     = s3_tag_q.row;
  assign res_o.col     = s3_tag_q.col;
  assign res_o.last    = s3_tag_q.last_pair;
  assign res_o.product = acc_sum;
  assign busy_o        = s1_vld_q || s2_vld_q || s3_vld_q;

endmodule

// ----- hw/rtl/diag_weighted_gram_product.sv -----
`timescale 1ns / 1ps

// Computes C = A * diag(w) * A^T over signed Q3.12 values, with exact sums kept as
// 50-bit signed words carrying 36 fractional bits. Load beats (matrix element or
// weight) are accepted back to back. A compute beat holds the input side until the
// final result element has been produced; elements leave in row-major order, the
// final one flagged by last_o. Each result element takes cols_in_use reads from the
// dual-read matrix memory, then passes through the read, the two multiply stages
// (the second feeding the accumulator) and the hand-off from the output register.
// Reading an element that was never loaded gives an unspecified value.

`include "diag_weighted_gram_product_assert.svh"

module diag_weighted_gram_product import dwgp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [DIM_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IDX_W-1:0]        out_row_o,
  output logic [IDX_W-1:0]        out_col_o,
  output logic signed [ACC_W-1:0] product_o,
  output logic                    last_o
);

  // Configuration registers.
  logic [DIM_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(MAX_ROWS);
      cols_q <= DIM_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROWS: rows_q <= cfg_wdata_i;
        REG_COLS: cols_q <= cfg_wdata_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  logic [DIM_W-1:0] nr, nc;
  logic [IDX_W-1:0] nr_last, nc_last;

  assign nr      = clamp_dim(rows_q, DIM_W'(MAX_ROWS));
  assign nc      = clamp_dim(cols_q, DIM_W'(MAX_COLS));
  assign nr_last = IDX_W'(nr - DIM_W'(1));
  assign nc_last = IDX_W'(nc - DIM_W'(1));

  dwgp_state_e state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic out_valid_q;
  logic in_beat, compute_beat, issue_en;
  dwgp_wr_t    wr;
  dwgp_issue_t iss;
  dwgp_res_t   res;
  logic        core_busy;

  assign in_beat      = in_valid_i && in_ready_o;
  assign compute_beat = in_beat && (kind_i == KIND_COMPUTE);

  // A new result element starts only once the output register is free.
  assign issue_en = (state_q == ST_ISSUE) && ((k_q != '0) || !out_valid_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (compute_beat) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_en && (k_q == nc_last)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res.valid) begin
          state_d = res.last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input ready, store writes and memory reads.
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    wr.mat_we      = in_beat && (kind_i == KIND_LOAD_A);
    wr.wgt_we      = in_beat && (kind_i == KIND_LOAD_W);
    wr.row         = row_index_i;
    wr.col         = col_index_i;
    wr.data        = value_i;
    iss.valid      = issue_en;
    iss.ka         = i_q;
    iss.kb_row     = j_q;
    iss.k          = k_q;
    iss.tag.first  = (k_q == '0);
    iss.tag.last_k = (k_q == nc_last);
    iss.tag.row    = i_q;
    iss.tag.col    = j_q;
    iss.tag.last_pair = (i_q == nr_last) && (j_q == nr_last);
  end

  // Loop counters: k innermost, then j, then i.
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (compute_beat) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end else if (issue_en) begin
      if (k_q == nc_last) begin
        k_d = '0;
        if (j_q == nr_last) begin
          j_d = '0;
          i_d = (i_q == nr_last) ? '0 : i_q + IDX_W'(1);
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end else begin
        k_d = k_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  dwgp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .iss_i  (iss),
    .res_o  (res),
    .busy_o (core_busy)
  );

  // Output register, holding a result beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_row_o <= res.row;
      out_col_o <= res.col;
      last_o    <= res.last;
      product_o <= res.product;
    end
  end

  assign out_valid_o = out_valid_q;

  // A finished element never lands on a result still waiting.
  `DWGP_ASSERT(a_no_overwrite, res.valid |-> !out_valid_q, "result overwrote pending beat")
  // The run ends right after its final element.
  `DWGP_ASSERT(a_last_ends_run, (res.valid && res.last) |=> (state_q == ST_IDLE), "run did not end")
  // Nothing is left in the pipeline once the block is idle.
  `DWGP_ASSERT(a_idle_drained, (state_q == ST_IDLE) |-> !core_busy, "pipeline busy while idle")

endmodule

// ----- sim/diag_weighted_gram_product_tb.sv -----
`timescale 1ns / 1ps

module diag_weighted_gram_product_tb;
  import dwgp_pkg::*;

  // Kind code that the block must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [VAL_W-1:0] VAL_MIN = 16'h8000;
  localparam logic [VAL_W-1:0] VAL_MAX = 16'h7fff;

  // Handshake pacing, in percent of cycles spent idle.
  localparam int unsigned IDLE_NONE  = 0;
  localparam int unsigned IDLE_HEAVY = 52;
  localparam int unsigned IDLE_BOTH  = 25;

  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned STALL_LIMIT   = 5000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } gram_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] product;
    logic             last;
  } gram_elem_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_index_i = REG_ROWS;
  logic [DIM_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              kind_i = KIND_LOAD_A;
  logic [IDX_W-1:0]        row_index_i = '0;
  logic [IDX_W-1:0]        col_index_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [IDX_W-1:0]        out_row_o;
  logic [IDX_W-1:0]        out_col_o;
  logic signed [ACC_W-1:0] product_o;
  logic                    last_o;

  // Beats waiting to be driven and result elements waiting to arrive.
  gram_beat_t pending_beats[$];
  gram_elem_t expected_elems[$];

  // Local copy of the block's stores and dimension registers.
  logic signed [VAL_W-1:0] a_store [MAX_ROWS][MAX_COLS];
  logic signed [VAL_W-1:0] w_store [MAX_COLS];
  logic [DIM_W-1:0]        rows_cfg = DIM_W'(8);
  logic [DIM_W-1:0]        cols_cfg = DIM_W'(8);

  int unsigned send_idle_pct  = IDLE_NONE;
  int unsigned recv_stall_pct = IDLE_NONE;
  int unsigned mismatch_count = 0;
  int unsigned beats_accepted = 0;
  int unsigned compute_runs   = 0;
  int unsigned elems_checked  = 0;
  int unsigned stall_cycles   = 0;

  diag_weighted_gram_product DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .product_o   (product_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  // A register value of zero means one; anything above the store size means the size.
  function automatic int unsigned used_dim(logic [DIM_W-1:0] v, int unsigned cap);
    if (v == '0) begin
      return 1;
    end
    if (v > cap) begin
      return cap;
    end
    return v;
  endfunction

  // Updates the local stores and, for a compute beat, queues every element of C.
  task automatic apply_beat(gram_beat_t b);
    int unsigned nr;
    int unsigned nc;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    longint      acc;
    gram_elem_t  e;
    case (b.kind)
      KIND_LOAD_A: begin
        a_store[b.row][b.col] = b.value;
      end
      KIND_LOAD_W: begin
        w_store[b.col] = b.value;
      end
      KIND_COMPUTE: begin
        nr = used_dim(rows_cfg, MAX_ROWS);
        nc = used_dim(cols_cfg, MAX_COLS);
        compute_runs++;
        for (i = 0; i < nr; i++) begin
          for (j = 0; j < nr; j++) begin
            acc = 0;
            for (k = 0; k < nc; k++) begin
              acc += longint'(a_store[i][k]) * longint'(a_store[j][k]) * longint'(w_store[k]);
            end
            e.row     = IDX_W'(i);
            e.col     = IDX_W'(j);
            e.product = acc[ACC_W-1:0];
            e.last    = (i == nr - 1) && (j == nr - 1);
            expected_elems.push_back(e);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Driver: takes the next beat when the current one has gone, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    gram_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_beat({kind_i, row_index_i, col_index_i, value_i});
        beats_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          in_valid_i  <= 1'b1;
          kind_i      <= nxt.kind;
          row_index_i <= nxt.row;
          col_index_i <= nxt.col;
          value_i     <= nxt.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result element against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    gram_elem_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        elems_checked++;
        if (expected_elems.size() == 0) begin
          report_mismatch($sformatf("unexpected element (%0d,%0d) product %0d",
                                    out_row_o, out_col_o, product_o));
        end else begin
          want = expected_elems.pop_front();
          if (out_row_o !== want.row) begin
            report_mismatch($sformatf("row %0d, wanted %0d", out_row_o, want.row));
          end
          if (out_col_o !== want.col) begin
            report_mismatch($sformatf("col %0d, wanted %0d", out_col_o, want.col));
          end
          if (product_o !== want.product) begin
            report_mismatch($sformatf("product at (%0d,%0d) is %0d, wanted %0d",
                                      want.row, want.col, product_o,
                                      $signed(want.product)));
          end
          if (last_o !== want.last) begin
            report_mismatch($sformatf("last at (%0d,%0d) is %0b, wanted %0b",
                                      want.row, want.col, last_o, want.last));
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when work is outstanding but no beat moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (!in_valid_i && pending_beats.size() == 0 && expected_elems.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAIL diag_weighted_gram_product");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic queue_beat(logic [1:0] k, int unsigned r, int unsigned c,
                            logic [VAL_W-1:0] v);
    pending_beats.push_back({k, IDX_W'(r), IDX_W'(c), v});
  endtask

  task automatic queue_compute();
    queue_beat(KIND_COMPUTE, $urandom_range(7), $urandom_range(7), rand_value());
  endtask

  // Writes the whole matrix and weight vector, with fixed or random values.
  task automatic queue_fill(bit random_vals, logic [VAL_W-1:0] a_val,
                            logic [VAL_W-1:0] w_val);
    int unsigned r;
    int unsigned c;
    for (r = 0; r < MAX_ROWS; r++) begin
      for (c = 0; c < MAX_COLS; c++) begin
        queue_beat(KIND_LOAD_A, r, c, random_vals ? rand_value() : a_val);
      end
    end
    for (c = 0; c < MAX_COLS; c++) begin
      queue_beat(KIND_LOAD_W, $urandom_range(7), c, random_vals ? rand_value() : w_val);
    end
  endtask

  // Random mix of loads and computes, with a little unused-kind noise on top.
  task automatic queue_mix(int unsigned n);
    int unsigned counted;
    int unsigned sel;
    counted = 0;
    while (counted < n) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        queue_beat(KIND_UNUSED, $urandom_range(7), $urandom_range(7), rand_value());
      end else begin
        counted++;
        if (sel < 9) begin
          queue_compute();
        end else if (sel < 27) begin
          queue_beat(KIND_LOAD_W, $urandom_range(7), $urandom_range(7), rand_value());
        end else begin
          queue_beat(KIND_LOAD_A, $urandom_range(7), $urandom_range(7), rand_value());
        end
      end
    end
  endtask

  // Waits until every beat is sent and every element has arrived, then lets the block settle.
  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (pending_beats.size() != 0 || in_valid_i || expected_elems.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROWS;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_index_i <= REG_COLS;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rows_cfg = rows;
    cols_cfg = cols;
    @(negedge clk_i);
  endtask

  // One random phase: new pacing and dimensions, with a full pause half way.
  task automatic run_phase(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                           int unsigned send_pct, int unsigned recv_pct, int unsigned n);
    wait_quiet();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_dims(rows, cols);
    queue_mix(n / 2);
    wait_quiet();
    queue_mix(n - n / 2);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a 1x1 product (both registers written as zero) at the value extremes.
    write_dims('0, '0);
    queue_beat(KIND_LOAD_A, 0, 0, VAL_MAX);
    queue_beat(KIND_LOAD_W, 7, 0, VAL_MAX);
    queue_beat(KIND_COMPUTE, 0, 0, '0);
    queue_beat(KIND_LOAD_A, 0, 0, VAL_MIN);
    queue_beat(KIND_LOAD_W, 0, 0, VAL_MIN);
    queue_beat(KIND_COMPUTE, 7, 7, VAL_MIN);
    queue_beat(KIND_LOAD_W, 0, 0, '0);
    queue_beat(KIND_COMPUTE, 0, 0, VAL_MAX);
    // An unused-kind beat must leave the stores alone.
    queue_beat(KIND_LOAD_W, 0, 0, VAL_MAX);
    queue_beat(KIND_UNUSED, 0, 0, 16'h0001);
    queue_beat(KIND_COMPUTE, 0, 0, '0);
    wait_quiet();
    write_dims(DIM_W'(2), DIM_W'(1));
    queue_beat(KIND_LOAD_A, 1, 0, VAL_MAX);
    queue_beat(KIND_COMPUTE, 0, 0, '0);
    wait_quiet();

    // Full 8x8 with registers above the maximum, and sums at their largest magnitudes.
    write_dims(DIM_W'(15), DIM_W'(9));
    queue_fill(1'b0, VAL_MIN, VAL_MIN);
    queue_compute();
    queue_fill(1'b0, VAL_MIN, VAL_MAX);
    queue_compute();
    queue_fill(1'b1, '0, '0);
    queue_compute();
    queue_mix(30);

    run_phase(DIM_W'(8), DIM_W'(8), IDLE_HEAVY, IDLE_NONE, 50);
    run_phase(DIM_W'(3), DIM_W'(5), IDLE_NONE, IDLE_HEAVY, 50);
    run_phase(DIM_W'(1), DIM_W'(8), IDLE_BOTH, IDLE_BOTH, 50);
    run_phase(DIM_W'(8), DIM_W'(1), IDLE_HEAVY, IDLE_HEAVY, 50);
    wait_quiet();

    if (expected_elems.size() != 0) begin
      report_mismatch($sformatf("%0d elements never arrived", expected_elems.size()));
    end
    $display("Sent %0d beats including %0d compute runs; checked %0d result elements.",
             beats_accepted, compute_runs, elems_checked);
    $display("Dimensions ran from 1x1 to 8x8 under four sender and receiver pacing modes.");
    if (mismatch_count == 0) begin
      $display("PASS diag_weighted_gram_product");
    end else begin
      $display("FAIL diag_weighted_gram_product");
    end
    $finish;
  end

endmodule
